// ----- hdl/rthsl_pkg.sv -----
package rthsl_pkg;

  localparam int unsigned ChBits   = 16;
  localparam int unsigned FracBits = 16;
  localparam int unsigned HueFrac  = 6;

  // A normalised fraction runs from zero to one inclusive.
  localparam int unsigned FxW = FracBits + 1;
  localparam logic [FxW-1:0] OneFx = FxW'(1) << FracBits;

  // Hue constants in 1/64 degree units.
  localparam int unsigned HueW = 15;
  localparam logic [HueW-1:0] Deg60  = HueW'(60 << HueFrac);
  localparam logic [HueW-1:0] Deg120 = HueW'(120 << HueFrac);
  localparam logic [HueW-1:0] Deg240 = HueW'(240 << HueFrac);
  localparam logic [HueW-1:0] Deg360 = HueW'(360 << HueFrac);

  // Width of the hue dividend, Deg60 times a fraction.
  localparam int unsigned HnW = FxW + 12;

  // Divider pipeline sizes: dividend, divisor and side data carried alongside.
  localparam int unsigned DivNW = FxW + FracBits;
  localparam int unsigned DivDW = FxW;
  localparam int unsigned DivSW = 2 + 2 + 1 + FxW;

  // Sector codes for the largest channel.
  localparam logic [1:0] SecRed   = 2'd0;
  localparam logic [1:0] SecGreen = 2'd1;
  localparam logic [1:0] SecBlue  = 2'd2;

  // Classified item as it passes from the front part to the back part.
  typedef struct packed {
    logic            ok;
    logic            grey;
    logic [1:0]      sector;
    logic            neg;
    logic [FxW-1:0]  delta;
    logic [FxW-1:0]  mag;
    logic [FxW-1:0]  den;
    logic [FxW:0]    sum;
  } cls_t;

endpackage

// ----- hdl/rthsl_div.sv -----
// Restoring divider pipeline, one quotient bit per stage.
// The quotient is clamped at one, and a zero divisor also yields one.
// Side data travels alongside the operands.
module rthsl_div import rthsl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DivNW-1:0] num_i,
  input  logic [DivDW-1:0] den_i,
  input  logic [DivSW-1:0] side_i,
  output logic             valid_o,
  output logic [FxW-1:0]   quo_o,
  output logic [DivSW-1:0] side_o
);

  // Each stage word holds the partial remainder above the shifting dividend.
  localparam int unsigned StW = DivDW + 1 + DivNW;

  logic [DivNW-1:0] vld_q;
  logic [StW-1:0]   step_d [DivNW];
  logic [StW-1:0]   step_q [DivNW];
  logic [DivDW-1:0] den_q  [DivNW];
  logic [DivSW-1:0] side_q [DivNW];
  logic [DivNW-1:0] last_num;
  logic             unused_rem;

  // One stage shifts in one dividend bit and tries a subtraction.
  function automatic logic [StW-1:0] div_step(logic [StW-1:0] st, logic [DivDW-1:0] den);
    logic [DivDW+1:0] trial;
    logic [DivDW:0]   rem_n;
    logic [DivNW-1:0] num_n;
    trial = {st[StW-1:DivNW], st[DivNW-1]};
    num_n = {st[DivNW-2:0], 1'b0};
    if (trial >= {2'b00, den}) begin
      rem_n    = (DivDW+1)'(trial - {2'b00, den});
      num_n[0] = 1'b1;
    end else begin
      rem_n = trial[DivDW:0];
    end
    return {rem_n, num_n};
  endfunction

  always_comb begin
    step_d[0] = div_step({(DivDW+1)'(0), num_i}, den_i);
    for (int k = 1; k < DivNW; k++) begin
      step_d[k] = div_step(step_q[k-1], den_q[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DivNW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
      for (int k = 0; k < DivNW; k++) begin
        step_q[k] <= step_d[k];
      end
      for (int k = 1; k < DivNW; k++) begin
        den_q[k]  <= den_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // After the last stage the dividend part holds the quotient.
  assign last_num   = step_q[DivNW-1][DivNW-1:0];
  assign unused_rem = ^step_q[DivNW-1][StW-1:DivNW];

  always_comb begin
    valid_o = vld_q[DivNW-1];
    side_o  = side_q[DivNW-1];
    if (den_q[DivNW-1] == '0 || last_num > DivNW'(OneFx)) begin
      quo_o = OneFx;
    end else begin
      quo_o = last_num[FxW-1:0];
    end
  end

endmodule

// ----- hdl/rthsl_front.sv -----
// Front part: normalises each colour by clear and classifies the item.
// Three divider pipelines run in lockstep; the classification follows in one stage.
module rthsl_front import rthsl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic [ChBits-1:0] red_count_i,
  input  logic [ChBits-1:0] green_count_i,
  input  logic [ChBits-1:0] blue_count_i,
  input  logic [ChBits-1:0] clear_count_i,
  output logic              valid_o,
  input  logic              stall_i,
  output cls_t              cls_o
);

  logic             en;
  logic             vr, vg, vb;
  logic [FxW-1:0]   r, g, b;
  logic [DivSW-1:0] side_r, side_g, side_b;
  logic             cls_vld_q;
  cls_t             cls_q;

  // The whole front advances together unless its output is held.
  assign en      = !(cls_vld_q && stall_i);
  assign stall_o = !en;

  rthsl_div u_div_r (
    .clk_i, .rst_ni, .en_i(en), .valid_i(valid_i),
    .num_i(DivNW'({red_count_i, FracBits'(0)})), .den_i(DivDW'(clear_count_i)),
    .side_i(DivSW'(clear_count_i != '0)), .valid_o(vr), .quo_o(r), .side_o(side_r)
  );
  rthsl_div u_div_g (
    .clk_i, .rst_ni, .en_i(en), .valid_i(valid_i),
    .num_i(DivNW'({green_count_i, FracBits'(0)})), .den_i(DivDW'(clear_count_i)),
    .side_i(DivSW'(clear_count_i != '0)), .valid_o(vg), .quo_o(g), .side_o(side_g)
  );
  rthsl_div u_div_b (
    .clk_i, .rst_ni, .en_i(en), .valid_i(valid_i),
    .num_i(DivNW'({blue_count_i, FracBits'(0)})), .den_i(DivDW'(clear_count_i)),
    .side_i(DivSW'(clear_count_i != '0)), .valid_o(vb), .quo_o(b), .side_o(side_b)
  );

  // Maximum, minimum and sector, with ties going to red and then green.
  cls_t           cls_d;
  logic [FxW-1:0] mx, mn, pa, pb;
  always_comb begin
    mx = r;
    cls_d.sector = SecRed;
    if (g > mx) begin
      mx = g;
      cls_d.sector = SecGreen;
    end
    if (b > mx) begin
      mx = b;
      cls_d.sector = SecBlue;
    end
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    case (cls_d.sector)
      SecGreen: begin pa = b; pb = r; end
      SecBlue:  begin pa = r; pb = g; end
      default:  begin pa = g; pb = b; end
    endcase
    cls_d.ok    = side_r[0] & side_g[0] & side_b[0];
    cls_d.delta = mx - mn;
    cls_d.grey  = (mx == mn);
    cls_d.neg   = pa < pb;
    cls_d.mag   = cls_d.neg ? pb - pa : pa - pb;
    cls_d.sum   = {1'b0, mx} + {1'b0, mn};
    if (cls_d.sum <= {1'b0, OneFx}) begin
      cls_d.den = cls_d.sum[FxW-1:0];
    end else begin
      cls_d.den = FxW'({OneFx, 1'b0} - cls_d.sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_vld_q <= 1'b0;
    end else if (en) begin
      cls_vld_q <= vr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cls_q <= cls_d;
    end
  end

  assign valid_o = cls_vld_q;
  assign cls_o   = cls_q;

  logic unused_v;
  assign unused_v = vg ^ vb ^ (^side_r[DivSW-1:1]) ^ (^side_g[DivSW-1:1])
                    ^ (^side_b[DivSW-1:1]);

endmodule

// ----- hdl/rthsl_fifo.sv -----
// Two-entry queue between the front and back parts.
module rthsl_fifo import rthsl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic stall_o,
  input  cls_t data_i,
  output logic valid_o,
  input  logic stall_i,
  output cls_t data_o
);

  cls_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign stall_o = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign push    = valid_i && !stall_o;
  assign pop     = valid_o && !stall_i;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

// ----- hdl/rthsl_back.sv -----
// Back part: saturation and hue quotients in two divider pipelines, then the hue sector step.
module rthsl_back import rthsl_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  cls_t            cls_i,
  output logic            valid_o,
  input  logic            stall_i,
  output logic            valid_res_o,
  output logic [HueW-1:0] hue_o,
  output logic [FxW-1:0]  saturation_o,
  output logic [FxW-1:0]  lightness_o
);

  logic             en, vs, vh;
  logic [FxW-1:0]   sat_q, hq;
  logic [DivSW-1:0] side_s, side_h;
  logic [HnW-1:0]   hnum;
  logic             out_vld_q;

  assign en      = !(out_vld_q && stall_i);
  assign stall_o = !en;
  assign hnum    = HnW'(cls_i.mag) * HnW'(Deg60);

  rthsl_div u_div_s (
    .clk_i, .rst_ni, .en_i(en), .valid_i(valid_i),
    .num_i({cls_i.delta, FracBits'(0)}), .den_i(cls_i.den),
    .side_i({cls_i.ok, cls_i.grey, cls_i.sector, cls_i.neg, cls_i.sum[FxW:1]}),
    .valid_o(vs), .quo_o(sat_q), .side_o(side_s)
  );
  // The hue dividend is widened so that both pipelines have the same depth.
  rthsl_div u_div_h (
    .clk_i, .rst_ni, .en_i(en), .valid_i(valid_i),
    .num_i(DivNW'(hnum)), .den_i(cls_i.delta), .side_i('0),
    .valid_o(vh), .quo_o(hq), .side_o(side_h)
  );

  // Apply the sector base and the sign, wrapping into the range below 360 degrees.
  logic            ok, grey, neg;
  logic [1:0]      sec;
  logic [FxW-1:0]  lig;
  logic [HueW-1:0] base, q, hue;
  logic [HueW:0]   hsum;
  always_comb begin
    {ok, grey, sec, neg, lig} = side_s;
    q = HueW'(hq);
    case (sec)
      SecGreen: base = Deg120;
      SecBlue:  base = Deg240;
      default:  base = '0;
    endcase
    if (!neg) begin
      hsum = {1'b0, base} + {1'b0, q};
    end else if (q > base) begin
      hsum = {1'b0, base} + {1'b0, Deg360} - {1'b0, q};
    end else begin
      hsum = {1'b0, base} - {1'b0, q};
    end
    if (hsum >= {1'b0, Deg360}) hsum = hsum - {1'b0, Deg360};
    hue = hsum[HueW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      valid_res_o  <= ok;
      hue_o        <= (ok && !grey) ? hue : '0;
      saturation_o <= (ok && !grey) ? sat_q : '0;
      lightness_o  <= ok ? lig : '0;
    end
  end

  assign valid_o = out_vld_q;

  logic unused_h;
  assign unused_h = vh ^ (^side_h);

endmodule

// ----- hdl/rgb_to_hsl_clear_normalized_top.sv -----
// Pipeline: the front (33 divider stages, classify, queue write), then the back
// (33 divider stages, output register); long restoring pipelines set the latency.
// Throughput: one item per cycle while stall_i is low.
// Reset: rst_ni clears all valid flags and the queue at once; no clearing pass is needed.
module rgb_to_hsl_clear_normalized_top import rthsl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic [ChBits-1:0] red_count_i,
  input  logic [ChBits-1:0] green_count_i,
  input  logic [ChBits-1:0] blue_count_i,
  input  logic [ChBits-1:0] clear_count_i,
  output logic              valid_o,
  input  logic              stall_i,
  output logic              valid_res_o,
  output logic [HueW-1:0]   hue_o,
  output logic [FxW-1:0]    saturation_o,
  output logic [FxW-1:0]    lightness_o
);

  logic fv, fs, qv, qs;
  cls_t fc, qc;

  rthsl_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .red_count_i, .green_count_i, .blue_count_i, .clear_count_i,
    .valid_o(fv), .stall_i(fs), .cls_o(fc)
  );

  rthsl_fifo u_fifo (
    .clk_i, .rst_ni, .valid_i(fv), .stall_o(fs), .data_i(fc),
    .valid_o(qv), .stall_i(qs), .data_o(qc)
  );

  rthsl_back u_back (
    .clk_i, .rst_ni, .valid_i(qv), .stall_o(qs), .cls_i(qc),
    .valid_o, .stall_i, .valid_res_o, .hue_o, .saturation_o, .lightness_o
  );

endmodule

// ----- sim/rgb_to_hsl_clear_normalized_top_test.sv -----
module rgb_to_hsl_clear_normalized_top_test;
  import rthsl_pkg::*;

  typedef struct packed {
    logic [ChBits-1:0] red;
    logic [ChBits-1:0] green;
    logic [ChBits-1:0] blue;
    logic [ChBits-1:0] clear;
  } reading_t;

  typedef struct packed {
    logic            ok;
    logic [HueW-1:0] hue;
    logic [FxW-1:0]  sat;
    logic [FxW-1:0]  light;
  } hsl_t;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned HoldOffLen = 400;

  logic              clk_i;
  logic              rst_ni;
  logic              valid_i;
  logic              stall_o;
  logic [ChBits-1:0] red_count_i;
  logic [ChBits-1:0] green_count_i;
  logic [ChBits-1:0] blue_count_i;
  logic [ChBits-1:0] clear_count_i;
  logic              valid_o;
  logic              stall_i;
  logic              valid_res_o;
  logic [HueW-1:0]   hue_o;
  logic [FxW-1:0]    saturation_o;
  logic [FxW-1:0]    lightness_o;

  reading_t pending_readings[$];
  hsl_t     expected_hsl[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_cycles;
  bit          hold_off_req;
  bit          hold_off_done;

  rgb_to_hsl_clear_normalized_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_i),
    .stall_o       (stall_o),
    .red_count_i   (red_count_i),
    .green_count_i (green_count_i),
    .blue_count_i  (blue_count_i),
    .clear_count_i (clear_count_i),
    .valid_o       (valid_o),
    .stall_i       (stall_i),
    .valid_res_o   (valid_res_o),
    .hue_o         (hue_o),
    .saturation_o  (saturation_o),
    .lightness_o   (lightness_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Divides a count by the clear count and clamps the ratio to one.
  function automatic logic [63:0] normalise(logic [ChBits-1:0] count, logic [ChBits-1:0] clr);
    logic [63:0] q;
    q = (64'(count) << FracBits) / 64'(clr);
    return (q > 64'(OneFx)) ? 64'(OneFx) : q;
  endfunction

  // Offset from a sector base, carrying the sign of a minus b.
  function automatic logic [63:0] sector_hue(logic [63:0] base, logic [63:0] a,
                                             logic [63:0] b, logic [63:0] delta);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (a >= b) ? a - b : b - a;
    q = (64'(Deg60) * mag) / delta;
    if (a >= b) return base + q;
    if (q > base) return base + 64'(Deg360) - q;
    return base - q;
  endfunction

  // Works out hue, saturation and lightness for one reading.
  function automatic hsl_t convert_reading(reading_t rd);
    hsl_t        res;
    logic [63:0] r, g, b, mx, mn, delta, s, den, sat, hue;
    res = '0;
    if (rd.clear == 0) return res;
    r = normalise(rd.red, rd.clear);
    g = normalise(rd.green, rd.clear);
    b = normalise(rd.blue, rd.clear);
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    s = mx + mn;
    sat = 0;
    hue = 0;
    if (delta != 0) begin
      den = (s <= 64'(OneFx)) ? s : 2 * 64'(OneFx) - s;
      if (den == 0) begin
        sat = 64'(OneFx);
      end else begin
        sat = (delta << FracBits) / den;
        if (sat > 64'(OneFx)) sat = 64'(OneFx);
      end
      if (mx == r) hue = sector_hue(64'(0), g, b, delta);
      else if (mx == g) hue = sector_hue(64'(Deg120), b, r, delta);
      else hue = sector_hue(64'(Deg240), r, g, delta);
      if (hue >= 64'(Deg360)) hue -= 64'(Deg360);
    end
    res.ok = 1'b1;
    res.hue = hue[HueW-1:0];
    res.sat = sat[FxW-1:0];
    res.light = s[FxW:1];
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("Mismatch on %s at cycle %0d: got %0d, expected %0d",
             what, cycle_count, got, want);
    mismatches++;
  endtask

  task automatic add_reading(int unsigned r, int unsigned g, int unsigned b, int unsigned c);
    reading_t rd;
    rd.red = r[ChBits-1:0];
    rd.green = g[ChBits-1:0];
    rd.blue = b[ChBits-1:0];
    rd.clear = c[ChBits-1:0];
    pending_readings.push_back(rd);
  endtask

  // A random count, biased towards the extremes and towards the clear count.
  function automatic int unsigned pick_count(int unsigned clr);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 16'hffff;
      2: return (clr * $urandom_range(0, 100)) / 100;
      3: return $urandom_range(0, 255);
      default: return $urandom_range(0, 16'hffff);
    endcase
  endfunction

  task automatic add_random_readings(int unsigned n);
    int unsigned c;
    int unsigned r;
    repeat (n) begin
      c = ($urandom_range(0, 19) == 0) ? 0 :
          ($urandom_range(0, 3) == 0) ? 16'hffff : $urandom_range(1, 16'hffff);
      r = pick_count(c);
      // Sometimes force ties between channels.
      case ($urandom_range(0, 5))
        0: add_reading(r, r, pick_count(c), c);
        1: add_reading(pick_count(c), r, r, c);
        2: add_reading(r, r, r, c);
        default: add_reading(r, pick_count(c), pick_count(c), c);
      endcase
    end
  endtask

  task automatic wait_for_drain();
    while (pending_readings.size() != 0 || valid_i || expected_hsl.size() != 0)
      @(posedge clk_i);
  endtask

  // Driver: offers the next pending reading at the falling edge.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_i <= 1'b0;
      red_count_i <= '0;
      green_count_i <= '0;
      blue_count_i <= '0;
      clear_count_i <= '0;
    end else begin
      if (!valid_i || !stall_o) begin
        if (pending_readings.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          reading_t rd;
          rd = pending_readings.pop_front();
          valid_i <= 1'b1;
          red_count_i <= rd.red;
          green_count_i <= rd.green;
          blue_count_i <= rd.blue;
          clear_count_i <= rd.clear;
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, with one long hold-off counted here once it is requested.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      stall_i <= 1'b0;
      hold_off_cycles <= 0;
      hold_off_done <= 1'b0;
    end else if (hold_off_req && !hold_off_done) begin
      hold_off_cycles <= HoldOffLen - 1;
      hold_off_done <= 1'b1;
      stall_i <= 1'b1;
    end else if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      stall_i <= 1'b1;
    end else begin
      stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Monitor: records accepted readings and checks accepted results.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (valid_i && !stall_o)
        expected_hsl.push_back(convert_reading({red_count_i, green_count_i,
                                                blue_count_i, clear_count_i}));
      if (valid_o && !stall_i) begin
        if (expected_hsl.size() == 0) begin
          report_mismatch("unexpected transfer", 1, 0);
        end else begin
          hsl_t want;
          want = expected_hsl.pop_front();
          if (valid_res_o !== want.ok) report_mismatch("valid_res", valid_res_o, want.ok);
          if (hue_o !== want.hue) report_mismatch("hue", hue_o, want.hue);
          if (saturation_o !== want.sat) report_mismatch("saturation", saturation_o, want.sat);
          if (lightness_o !== want.light) report_mismatch("lightness", lightness_o, want.light);
        end
      end
      if (cycle_count >= CycleLimit) begin
        $display("Timeout after %0d cycles", cycle_count);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Stimulus and phase control.
  initial begin
    rst_ni = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_req = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed readings: extremes, invalid, grey, ties and every sector.
    add_reading(0, 0, 0, 0);
    add_reading(16'hffff, 16'hffff, 16'hffff, 0);
    add_reading(0, 0, 0, 1);
    add_reading(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    add_reading(16'hffff, 16'hffff, 16'hffff, 1);
    add_reading(16'hffff, 0, 0, 16'hffff);
    add_reading(0, 16'hffff, 0, 16'hffff);
    add_reading(0, 0, 16'hffff, 16'hffff);
    add_reading(1000, 200, 600, 1000);
    add_reading(1000, 600, 200, 1000);
    add_reading(200, 1000, 600, 1000);
    add_reading(600, 1000, 200, 1000);
    add_reading(200, 600, 1000, 1000);
    add_reading(600, 200, 1000, 1000);
    add_reading(500, 500, 100, 1000);
    add_reading(100, 500, 500, 1000);
    add_reading(500, 100, 500, 1000);
    add_reading(300, 300, 300, 1000);
    add_reading(16'haaaa, 16'h5555, 16'h0001, 16'hffff);
    add_reading(16'h5555, 16'haaaa, 16'hfffe, 16'h8000);
    add_reading(900, 1, 0, 1000);
    add_reading(1, 0, 0, 2);
    wait_for_drain();

    // Phase with no idling, with a long receiver hold-off partway through.
    add_random_readings(300);
    wait (pending_readings.size() < 200);
    hold_off_req = 1'b1;
    wait_for_drain();

    send_idle_pct = 78;
    add_random_readings(320);
    wait_for_drain();

    send_idle_pct = 0;
    recv_stall_pct = 78;
    add_random_readings(320);
    wait_for_drain();

    send_idle_pct = 36;
    recv_stall_pct = 36;
    add_random_readings(320);
    wait_for_drain();

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_hsl.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
